### sv/ecnq_pkg.sv
// Shared types and constants for the ECN-marking egress queue.
// Used by ecnq_ram and ecn_marking_egress_queue; depends on nothing.
package ecnq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;

  localparam int TAG_W   = 16;
  localparam int LEN_W   = 16;
  localparam int BYTES_W = 24;
  localparam int THR_W   = 12;
  localparam int FRAME_W = 16;
  localparam int LIMIT_W = THR_W + FRAME_W;

  localparam logic [BYTES_W-1:0] BYTE_MAX = {BYTES_W{1'b1}};

  // commands
  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TX_DONE = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ECN_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = 2'd2;

  localparam logic [FRAME_W-1:0] FRAME_SIZE_RESET = 16'd1500;

  typedef struct packed {
    logic             cmd;
    logic [TAG_W-1:0] pkt_tag;
    logic [LEN_W-1:0] pkt_bytes;
    logic             pkt_ecn_in;
  } in_item_t;

  typedef struct packed {
    logic               tx_valid;
    logic [TAG_W-1:0]   tx_tag;
    logic [LEN_W-1:0]   tx_bytes;
    logic               tx_ecn;
    logic               dropped;
    logic [BYTES_W-1:0] queued_bytes_now;
  } result_t;

  // one queued descriptor
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] bytes;
    logic             ecn;
  } slot_t;

endpackage

### sv/ecnq_ram.sv
// Descriptor store for the egress queue: one write port, one registered read port.
// Depends on ecnq_pkg for slot_t.
module ecnq_ram #(
  parameter int DEPTH = ecnq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  ecnq_pkg::slot_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output ecnq_pkg::slot_t rd_data
);
  import ecnq_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/ecn_marking_egress_queue.sv
// Egress port queue with ECN marking and tail drop; top level.
// Depends on ecnq_pkg and ecnq_ram (descriptor memory).
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  --------------------------
//  command   in         start & !busy       item   (in_item_t)
//  result    out        done, one cycle     result (result_t)
//  config    in         cfg_valid&cfg_ready cfg_index, cfg_data
//
// Each item has an accept step and a decide step: the accept edge reads the
// head descriptor from the memory, the next edge decides, updates state and
// registers the result. done pulses in the cycle after that, while busy is low
// again, so a new item can be accepted then. The registered memory read sets this.
// Reset (rst, synchronous) empties the queue, idles the line and restores the
// register defaults. The result cannot be stalled; cfg_ready is always high.
module ecn_marking_egress_queue #(
  parameter int QUEUE_DEPTH = ecnq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  ecnq_pkg::in_item_t                   item,
  output logic                                 done,
  output ecnq_pkg::result_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ecnq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ecnq_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ecnq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(QUEUE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;

  logic [THR_W-1:0]   ecn_threshold_frames;
  logic [FRAME_W-1:0] frame_size_bytes;
  logic [BYTES_W-1:0] capacity_bytes;
  logic [LIMIT_W-1:0] mark_limit;

  logic [AW-1:0]      fifo_head, fifo_head_next;
  logic [AW-1:0]      fifo_tail, fifo_tail_next;
  logic [CW-1:0]      fifo_count, fifo_count_next;
  logic [BYTES_W-1:0] byte_total, byte_total_next;
  logic               line_busy, line_busy_next;

  in_item_t cur;
  slot_t    head_slot;
  slot_t    wr_slot;
  logic     wr_en;
  result_t  result_next;

  logic               accept;
  logic               mark;
  logic               drop;
  logic [BYTES_W:0]   sum_total;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state == ST_EXEC);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ecn_threshold_frames <= '0;
      frame_size_bytes     <= FRAME_SIZE_RESET;
      capacity_bytes       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ECN_THRESHOLD: ecn_threshold_frames <= cfg_data[THR_W-1:0];
        CFG_FRAME_SIZE:    frame_size_bytes     <= cfg_data[FRAME_W-1:0];
        CFG_CAPACITY:      capacity_bytes       <= cfg_data[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // 12x16 product, follows a register write with no lag
  assign mark_limit = LIMIT_W'(ecn_threshold_frames) * LIMIT_W'(frame_size_bytes);

  ecnq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fifo_tail),
    .wr_data (wr_slot),
    .rd_en   (accept),
    .rd_addr (fifo_head),
    .rd_data (head_slot)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
  end

  always_comb begin
    fifo_head_next  = fifo_head;
    fifo_tail_next  = fifo_tail;
    fifo_count_next = fifo_count;
    byte_total_next = byte_total;
    line_busy_next  = line_busy;
    wr_en           = 1'b0;
    result_next     = '0;
    mark = (ecn_threshold_frames != '0) &&
           ({{(LIMIT_W-BYTES_W){1'b0}}, byte_total} >= mark_limit);
    sum_total = {1'b0, byte_total} + (BYTES_W+1)'(cur.pkt_bytes);
    drop = ((capacity_bytes != '0) && (byte_total >= capacity_bytes)) ||
           (fifo_count >= COUNT_FULL) ||
           (sum_total > {1'b0, BYTE_MAX});
    wr_slot.tag   = cur.pkt_tag;
    wr_slot.bytes = cur.pkt_bytes;
    wr_slot.ecn   = cur.pkt_ecn_in | mark;

    if (cur.cmd == CMD_TX_DONE) begin
      line_busy_next = 1'b0;
      if (fifo_count != '0) begin
        fifo_head_next  = (fifo_head == PTR_LAST) ? '0 : fifo_head + 1'b1;
        fifo_count_next = fifo_count - 1'b1;
        byte_total_next = ({8'd0, head_slot.bytes} <= byte_total) ?
                          byte_total - {8'd0, head_slot.bytes} : '0;
        result_next.tx_valid = 1'b1;
        result_next.tx_tag   = head_slot.tag;
        result_next.tx_bytes = head_slot.bytes;
        result_next.tx_ecn   = head_slot.ecn;
        line_busy_next       = 1'b1;
      end
    end else if (!line_busy) begin
      result_next.tx_valid = 1'b1;
      result_next.tx_tag   = cur.pkt_tag;
      result_next.tx_bytes = cur.pkt_bytes;
      result_next.tx_ecn   = cur.pkt_ecn_in;
      line_busy_next       = 1'b1;
    end else if (drop) begin
      result_next.dropped = 1'b1;
    end else begin
      wr_en           = 1'b1;
      fifo_tail_next  = (fifo_tail == PTR_LAST) ? '0 : fifo_tail + 1'b1;
      fifo_count_next = fifo_count + 1'b1;
      byte_total_next = sum_total[BYTES_W-1:0];
    end
    result_next.queued_bytes_now = byte_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
      byte_total <= '0;
      line_busy  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          fifo_head  <= fifo_head_next;
          fifo_tail  <= fifo_tail_next;
          fifo_count <= fifo_count_next;
          byte_total <= byte_total_next;
          line_busy  <= line_busy_next;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      result <= result_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= COUNT_FULL)
    else $error("queue count beyond depth");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (fifo_count == '0) |-> (byte_total == '0))
    else $error("bytes held by an empty queue");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    ((fifo_count == '0) || (fifo_count == COUNT_FULL)) |-> (fifo_head == fifo_tail))
    else $error("head and tail disagree with count");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_EXEC))
    else $error("result strobe without an item in work");

  a_drop_no_tx: assert property (@(posedge clk) disable iff (rst)
    (done && result.dropped) |-> !result.tx_valid)
    else $error("dropped item also transmitted");

endmodule

### test/ecnq_checker.sv
// Checker for the ECN-marking egress queue: mirrors the queue state, forecasts
// one result per accepted item and compares results as they come out.
// Depends on ecnq_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps

module ecnq_checker #(
  parameter int QUEUE_DEPTH = ecnq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  ecnq_pkg::in_item_t              item,
  input  logic                            done,
  input  ecnq_pkg::result_t               result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ecnq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecnq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              outstanding,
  output int                              results_checked,
  output int                              drops_seen,
  output int                              marks_seen
);
  import ecnq_pkg::*;

  // mirror of the queue
  slot_t              desc_mem [QUEUE_DEPTH];
  int                 rd_ptr;
  int                 wr_ptr;
  int                 n_queued;
  logic [BYTES_W-1:0] bytes_queued;
  logic               line_active;

  // mirror of the registers
  logic [THR_W-1:0]   thr_frames;
  logic [FRAME_W-1:0] frame_bytes;
  logic [BYTES_W-1:0] cap_bytes;

  result_t egress_results_due [$];
  int      n_fail;
  int      n_checked;
  int      n_drops;
  int      n_marks;

  function automatic result_t egress_step(in_item_t it);
    result_t            r;
    slot_t              s;
    logic [LIMIT_W-1:0] mark_level;
    logic [BYTES_W:0]   sum;
    logic               ecn;
    r   = '0;
    ecn = it.pkt_ecn_in;
    if (it.cmd == CMD_TX_DONE) begin
      line_active = 1'b0;
      if (n_queued != 0) begin
        s            = desc_mem[rd_ptr];
        rd_ptr       = (rd_ptr == QUEUE_DEPTH - 1) ? 0 : rd_ptr + 1;
        n_queued     = n_queued - 1;
        bytes_queued = (BYTES_W'(s.bytes) <= bytes_queued) ?
                       bytes_queued - BYTES_W'(s.bytes) : '0;
        r.tx_valid   = 1'b1;
        r.tx_tag     = s.tag;
        r.tx_bytes   = s.bytes;
        r.tx_ecn     = s.ecn;
        line_active  = 1'b1;
      end
    end else if (!line_active) begin
      // idle line: straight out, mark untouched
      r.tx_valid  = 1'b1;
      r.tx_tag    = it.pkt_tag;
      r.tx_bytes  = it.pkt_bytes;
      r.tx_ecn    = it.pkt_ecn_in;
      line_active = 1'b1;
    end else begin
      mark_level = LIMIT_W'(thr_frames) * LIMIT_W'(frame_bytes);
      if (thr_frames != 0 && LIMIT_W'(bytes_queued) >= mark_level)
        ecn = 1'b1;
      sum = (BYTES_W+1)'(bytes_queued) + (BYTES_W+1)'(it.pkt_bytes);
      if ((cap_bytes != 0 && bytes_queued >= cap_bytes) || n_queued >= QUEUE_DEPTH ||
          sum > (BYTES_W+1)'(BYTE_MAX)) begin
        r.dropped = 1'b1;
      end else begin
        desc_mem[wr_ptr] = '{tag: it.pkt_tag, bytes: it.pkt_bytes, ecn: ecn};
        wr_ptr           = (wr_ptr == QUEUE_DEPTH - 1) ? 0 : wr_ptr + 1;
        n_queued         = n_queued + 1;
        bytes_queued     = sum[BYTES_W-1:0];
      end
    end
    r.queued_bytes_now = bytes_queued;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    string   bad;
    if (rst) begin
      rd_ptr       = 0;
      wr_ptr       = 0;
      n_queued     = 0;
      bytes_queued = '0;
      line_active  = 1'b0;
      thr_frames   = '0;
      frame_bytes  = FRAME_SIZE_RESET;
      cap_bytes    = '0;
      n_fail       = 0;
      n_checked    = 0;
      n_drops      = 0;
      n_marks      = 0;
      egress_results_due.delete();
    end else begin
      if (done) begin
        if (egress_results_due.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result with nothing pending: %p", $time, result);
        end else begin
          want = egress_results_due.pop_front();
          n_checked++;
          bad = "";
          if (result.tx_valid !== want.tx_valid) bad = {bad, " tx_valid"};
          if (result.tx_tag !== want.tx_tag) bad = {bad, " tx_tag"};
          if (result.tx_bytes !== want.tx_bytes) bad = {bad, " tx_bytes"};
          if (result.tx_ecn !== want.tx_ecn) bad = {bad, " tx_ecn"};
          if (result.dropped !== want.dropped) bad = {bad, " dropped"};
          if (result.queued_bytes_now !== want.queued_bytes_now)
            bad = {bad, " queued_bytes_now"};
          if (bad != "") begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: result %0d wrong in%s", $time, n_checked, bad);
              $display("  expected v=%0b tag=%h len=%h ecn=%0b drop=%0b q=%0d",
                       want.tx_valid, want.tx_tag, want.tx_bytes, want.tx_ecn,
                       want.dropped, want.queued_bytes_now);
              $display("  actual   v=%0b tag=%h len=%h ecn=%0b drop=%0b q=%0d",
                       result.tx_valid, result.tx_tag, result.tx_bytes, result.tx_ecn,
                       result.dropped, result.queued_bytes_now);
            end
          end
          if (want.dropped) n_drops++;
          if (want.tx_valid && want.tx_ecn) n_marks++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ECN_THRESHOLD: thr_frames  = cfg_data[THR_W-1:0];
          CFG_FRAME_SIZE:    frame_bytes = cfg_data[FRAME_W-1:0];
          CFG_CAPACITY:      cap_bytes   = cfg_data[BYTES_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        egress_results_due.push_back(egress_step(item));
    end
    fail_count      <= n_fail;
    outstanding     <= egress_results_due.size();
    results_checked <= n_checked;
    drops_seen      <= n_drops;
    marks_seen      <= n_marks;
  end

endmodule

### test/ecn_marking_egress_queue_test.sv
// Testbench top for ecn_marking_egress_queue: drives directed and random
// arrival/transmit-done items and register settings; ecnq_checker judges results.
// Depends on ecnq_pkg, ecnq_checker and the block itself.
`timescale 1ns / 100ps

module ecn_marking_egress_queue_test;
  import ecnq_pkg::*;

  localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam int RANDOM_ITEMS = 1650;
  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  in_item_t              item      = '0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  done;
  result_t               result;
  logic                  cfg_ready;

  int fail_count;
  int outstanding;
  int results_checked;
  int drops_seen;
  int marks_seen;

  int cycle_count = 0;
  int n_items     = 0;
  int n_tx_done   = 0;
  int n_settings  = 0;

  ecn_marking_egress_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) i_dut (
    .clk, .rst, .start, .busy, .item, .done, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ecnq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) i_checker (
    .clk, .rst, .start, .busy, .item, .done, .result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .outstanding, .results_checked, .drops_seen, .marks_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic cmd, logic [TAG_W-1:0] tag,
                                         logic [LEN_W-1:0] len, logic ecn);
    in_item_t it;
    it.cmd        = cmd;
    it.pkt_tag    = tag;
    it.pkt_bytes  = len;
    it.pkt_ecn_in = ecn;
    return it;
  endfunction

  function automatic in_item_t random_item(int arrival_pct);
    logic [LEN_W-1:0] len;
    case ($urandom_range(0, 9))
      0:       len = '0;
      1:       len = '1;
      2:       len = LEN_W'($urandom);
      default: len = LEN_W'($urandom_range(1, 2000));
    endcase
    // transmit-done items still carry random payload bits
    return make_item(($urandom_range(1, 100) <= arrival_pct) ? CMD_ARRIVAL : CMD_TX_DONE,
                     TAG_W'($urandom), len, 1'($urandom_range(0, 1)));
  endfunction

  // start stays high across back-to-back items
  task automatic send(input in_item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    n_items++;
    if (it.cmd == CMD_TX_DONE) n_tx_done++;
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // pause the sender until every forecast result has come out
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [THR_W-1:0] thr, input logic [FRAME_W-1:0] frame,
                            input logic [BYTES_W-1:0] cap);
    write_reg(CFG_ECN_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_FRAME_SIZE, CFG_DATA_W'(frame));
    write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    logic [THR_W-1:0]   thr;
    logic [FRAME_W-1:0] frame;
    logic [BYTES_W-1:0] cap;
    int                 base_pct;
    int                 pct;
    int                 burst;
    int                 phase_count;
    int                 n_random;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // register defaults: no marking, no byte limit
    send(make_item(CMD_TX_DONE, 16'h5a5a, 16'h0000, 1'b1)); // idle line, empty queue
    send(make_item(CMD_ARRIVAL, 16'h0000, 16'h0000, 1'b0)); // zero length, sent at once
    send(make_item(CMD_ARRIVAL, 16'hffff, 16'hffff, 1'b1));
    send(make_item(CMD_ARRIVAL, 16'h1234, 16'h0001, 1'b0));
    send(make_item(CMD_TX_DONE, 16'h0000, 16'hffff, 1'b0));
    send(make_item(CMD_TX_DONE, 16'hffff, 16'h0000, 1'b1));
    send(make_item(CMD_TX_DONE, 16'h0000, 16'h0000, 1'b0)); // line goes idle
    send(make_item(CMD_TX_DONE, 16'h0000, 16'h0000, 1'b0));

    // zero frame size: every queued arrival gets marked; small byte limit
    drain();
    write_reg(CFG_UNUSED, 24'ha5a5a5);
    set_config(12'd1, 16'd0, 24'd100);
    send(make_item(CMD_ARRIVAL, 16'h0101, 16'd500, 1'b0));
    send(make_item(CMD_ARRIVAL, 16'h0102, 16'd60, 1'b0));
    send(make_item(CMD_ARRIVAL, 16'h0103, 16'd60, 1'b0));
    send(make_item(CMD_ARRIVAL, 16'h0104, 16'd10, 1'b1));  // over the limit: dropped
    send(make_item(CMD_TX_DONE, 16'h0000, 16'h0000, 1'b0));
    send(make_item(CMD_TX_DONE, 16'h0000, 16'h0000, 1'b0));
    send(make_item(CMD_TX_DONE, 16'h0000, 16'h0000, 1'b0));

    // all registers at their maximum
    drain();
    set_config('1, '1, '1);
    send(make_item(CMD_ARRIVAL, 16'h0201, 16'hffff, 1'b0));
    send(make_item(CMD_ARRIVAL, 16'h0202, 16'hffff, 1'b0));
    send(make_item(CMD_TX_DONE, 16'h0000, 16'h0000, 1'b0));
    send(make_item(CMD_TX_DONE, 16'h0000, 16'h0000, 1'b0));

    // marking right at the threshold
    drain();
    set_config(12'd2, 16'd1000, 24'd0);
    send(make_item(CMD_ARRIVAL, 16'h0301, 16'd100, 1'b0));
    send(make_item(CMD_ARRIVAL, 16'h0302, 16'd1500, 1'b0));
    send(make_item(CMD_ARRIVAL, 16'h0303, 16'd500, 1'b0)); // reaches exactly 2000
    send(make_item(CMD_ARRIVAL, 16'h0304, 16'd100, 1'b0)); // marked

    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = '1;
        2, 3:    thr = THR_W'($urandom_range(1, 16));
        default: thr = THR_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:             frame = '0;
        1:             frame = 16'd1;
        2:             frame = '1;
        3, 4, 5, 6:    frame = FRAME_W'($urandom_range(1, 3000));
        default:       frame = FRAME_W'($urandom);
      endcase
      case ($urandom_range(0, 6))
        0, 1:    cap = '0;
        2:       cap = '1;
        3, 4:    cap = BYTES_W'($urandom_range(1, 60000));
        default: cap = BYTES_W'($urandom);
      endcase
      set_config(thr, frame, cap);
      case ($urandom_range(0, 4))
        0:       base_pct = 20;
        1:       base_pct = 50;
        2:       base_pct = 65;
        3:       base_pct = 80;
        default: base_pct = 95;
      endcase
      phase_count = 0;
      while (phase_count < PHASE_ITEMS && n_random < RANDOM_ITEMS) begin
        // flip the mix now and then so the queue fills and empties
        pct = ($urandom_range(0, 3) == 0) ? 100 - base_pct : base_pct;
        burst = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        repeat (burst) begin
          send(random_item(pct));
          phase_count++;
          n_random++;
        end
        case ($urandom_range(0, 7))
          0, 1:    hold_off(0);
          2:       hold_off($urandom_range(10, 20));
          default: hold_off($urandom_range(1, 7));
        endcase
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d items (%0d transmit-done) over %0d register settings.",
             n_items, n_tx_done, n_settings);
    $display("Checked %0d results: %0d drops, %0d marked transmissions.",
             results_checked, drops_seen, marks_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d result failures", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
